/* src/heap_sorter_core_assert.svh */
// Assertion macros shared by the heap sorter checker.
`ifndef HEAP_SORTER_CORE_ASSERT_SVH
`define HEAP_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap sorter check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define HS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap sorter check failed");

`endif

/* src/hsort_pkg.sv */
// Shared constants and types of the heap sorter.
package hsort_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int PORT_W    = 32;
  localparam int STORE_W   = (KEY_WIDTH < PORT_W) ? KEY_WIDTH : PORT_W;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [PORT_W-1:0]  port_key_t;
  typedef logic [STORE_W-1:0] store_key_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

endpackage

/* src/hsort_if.sv */
// Channel interfaces: key items in, sorted result items out.
interface hsort_key_if import hsort_pkg::*; ();
  logic      valid;
  logic      ready;
  port_key_t key;
  logic      is_last;

  modport source (output valid, output key, output is_last, input ready);
  modport sink   (input valid, input key, input is_last, output ready);
endinterface

interface hsort_result_if import hsort_pkg::*; ();
  logic      valid;
  logic      ready;
  port_key_t sorted_key;
  logic      end_of_set;
  logic      overflowed;

  modport source (output valid, output sorted_key, output end_of_set, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_key, input end_of_set, input overflowed,
                  output ready);
endinterface

/* src/hsort_cell.sv */
// One cell of the sorting chain: holds one key, inserts or shifts toward the head.
module hsort_cell import hsort_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  store_key_t new_key,
  input  store_key_t prev_key,
  input  logic       prev_valid,
  input  logic       prev_gt,
  input  store_key_t next_key,
  input  logic       next_valid,
  output store_key_t key,
  output logic       valid,
  output logic       gt
);

  // Empty cells count as larger than any key.
  assign gt = !valid || (key > new_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (ctrl.insert && gt) begin
        if (prev_gt) begin
          key   <= prev_key;
          valid <= prev_valid;
        end else begin
          key   <= new_key;
          valid <= 1'b1;
        end
      end else if (ctrl.drain) begin
        key   <= next_key;
        valid <= next_valid;
      end
    end
  end

endmodule

/* src/heap_sorter_core.sv */
// Heap sorter top level: sorts a set of keys and emits them in ascending order.
// Keys enter one per cycle on key_ch; each one is placed straight into its sorted
// position in a chain of DEPTH cells, every cell comparing the new key with its own
// and taking either the new key or its lower neighbor's key, so the chain is always
// ascending from cell 0. An item marked is_last closes the set: key_ch then drops
// ready and the chain shifts toward cell 0 one step per result taken, feeding an
// output register on result_ch. Keys arriving with the chain full are dropped, and
// the final result of the set carries overflowed. No clearing pass is needed after
// reset: cells are emptied by their valid bits.
module heap_sorter_core import hsort_pkg::*; (
  input logic             clk,
  input logic             rst,
  hsort_key_if.sink       key_ch,
  hsort_result_if.source  result_ch
);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic       state;
  count_t     key_count;
  logic       drop_flag;

  cell_ctrl_t ctrl;
  store_key_t new_key;
  store_key_t cell_key   [DEPTH];
  logic       cell_valid [DEPTH];
  logic       cell_gt    [DEPTH];

  logic       in_fire;
  logic       full;
  logic       out_load;

  // Output register.
  logic       out_valid;
  port_key_t  out_key;
  logic       out_end;
  logic       out_ovf;

  assign full    = (key_count == count_t'(DEPTH));
  assign in_fire = key_ch.valid && key_ch.ready;
  assign new_key = key_ch.key[STORE_W-1:0];

  assign key_ch.ready = (state == ST_FILL);

  // While draining, load the output register whenever it is empty or being emptied this cycle.
  assign out_load = (state == ST_DRAIN) && (!out_valid || result_ch.ready);

  assign ctrl = '{insert: in_fire && !full, drain: out_load};

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      store_key_t pk;
      logic       pv;
      logic       pg;
      store_key_t nk;
      logic       nv;

      // Cell 0 has no lower neighbor; the top cell shifts in an empty slot.
      if (i == 0) begin : g_head
        assign pk = '0;
        assign pv = 1'b0;
        assign pg = 1'b0;
      end else begin : g_mid
        assign pk = cell_key[i-1];
        assign pv = cell_valid[i-1];
        assign pg = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign nk = '0;
        assign nv = 1'b0;
      end else begin : g_body
        assign nk = cell_key[i+1];
        assign nv = cell_valid[i+1];
      end

      hsort_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_key    (new_key),
        .prev_key   (pk),
        .prev_valid (pv),
        .prev_gt    (pg),
        .next_key   (nk),
        .next_valid (nv),
        .key        (cell_key[i]),
        .valid      (cell_valid[i]),
        .gt         (cell_gt[i])
      );
    end
  endgenerate

  // Set bookkeeping: count keys while filling, count down results while draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      key_count <= '0;
      drop_flag <= 1'b0;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (in_fire) begin
            if (full) begin
              drop_flag <= 1'b1;
            end else begin
              key_count <= key_count + count_t'(1);
            end
            if (key_ch.is_last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            key_count <= key_count - count_t'(1);
            if (key_count == count_t'(1)) begin
              drop_flag <= 1'b0;
              state     <= ST_FILL;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  // Hold the result until taken; advance from cell 0 of the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_key <= PORT_W'(cell_key[0]);
      out_end <= (key_count == count_t'(1));
      out_ovf <= (key_count == count_t'(1)) && drop_flag;
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.sorted_key = out_key;
  assign result_ch.end_of_set = out_end;
  assign result_ch.overflowed = out_ovf;

endmodule

/* src/hsort_checker.sv */
// Port-level checks of the heap sorter, bound to the top level.
`include "heap_sorter_core_assert.svh"

module hsort_checker import hsort_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      in_last,
  input logic      out_valid,
  input logic      out_ready,
  input port_key_t out_key,
  input logic      out_end,
  input logic      out_ovf
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // A stalled result holds its key.
  `HS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key))
  // Overflow is reported only on the final item of a set.
  `HS_ASSERT_NOW(a_ovf_on_end, out_valid && out_ovf, out_end)
  // Closing a set stops intake while the set is emitted.
  `HS_ASSERT_NEXT(a_last_busy, in_fire && in_last, !in_ready)
  // An item that does not close the set leaves intake open.
  `HS_ASSERT_NEXT(a_fill_open, in_fire && !in_last, in_ready)

endmodule

bind heap_sorter_core hsort_checker u_hsort_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (key_ch.valid),
  .in_ready  (key_ch.ready),
  .in_last   (key_ch.is_last),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_key   (result_ch.sorted_key),
  .out_end   (result_ch.end_of_set),
  .out_ovf   (result_ch.overflowed)
);
